[sv/assert_macros.svh]
// Assertion macros for the checker module of the timer.
// Depends on nothing; each file that asserts includes it by name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent and consequent in the same cycle.
`define ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[sv/dts_pkg.sv]
// Package for the seconds and milliseconds deadline timer.
// Holds the field widths, the arithmetic constants, the operation codes and stage types.
`timescale 1ns / 1ps
package dts_pkg;

   localparam int unsigned OP_W       = 2;
   localparam int unsigned WORD_W     = 32;
   localparam int unsigned MSEC_W     = 10;
   localparam int unsigned SAT_W      = 29;
   localparam int unsigned SD_SEC_W   = 20;
   localparam int unsigned PROD_W     = 59;
   localparam int unsigned RECIP_SHIFT = 39;

   localparam logic [WORD_W-1:0] MAX_DELAY   = 32'd536870911;
   localparam logic [29:0]       RECIP_1000  = 30'd549755814;
   localparam logic [10:0]       ONE_SEC_MS  = 11'd1000;
   localparam logic [10:0]       TWO_SEC_MS  = 11'd2000;

   typedef enum logic [OP_W-1:0] {
      OP_SET     = 2'd0,
      OP_RESTART = 2'd1,
      OP_ADVANCE = 2'd2,
      OP_QUERY   = 2'd3
   } dts_op_type;

   typedef struct packed {
      dts_op_type        op;
      logic [WORD_W-1:0] delay_ms;
      logic [WORD_W-1:0] now_sec;
      logic [MSEC_W-1:0] now_msec;
   } dts_stage_a_type;

   typedef struct packed {
      dts_op_type          op;
      logic                zero;
      logic [SD_SEC_W-1:0] dly_sec;
      logic [MSEC_W-1:0]   dly_msec;
      logic [WORD_W-1:0]   now_sec;
      logic [MSEC_W-1:0]   now_msec;
   } dts_stage_b_type;

   typedef struct packed {
      logic               timed_out;
      logic               live;
      logic [WORD_W-1:0]  diff_sec;
      logic signed [10:0] diff_msec;
   } dts_stage_c_type;

   typedef struct packed {
      logic              timed_out;
      logic [WORD_W-1:0] remaining_ms;
   } dts_out_type;

endpackage

[sv/dts_if.sv]
// Handshake channels of the deadline timer: request words in, response words out.
// Depends on dts_pkg for the field widths.
`timescale 1ns / 1ps
interface dts_req_if import dts_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [OP_W-1:0]   op;
   logic [WORD_W-1:0] delay_ms;
   logic [WORD_W-1:0] now_sec;
   logic [MSEC_W-1:0] now_msec;

   modport source (output valid, op, delay_ms, now_sec, now_msec, input ready);
   modport sink   (input valid, op, delay_ms, now_sec, now_msec, output ready);
endinterface

interface dts_rsp_if import dts_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              timed_out;
   logic [WORD_W-1:0] remaining_ms;

   modport source (output valid, timed_out, remaining_ms, input ready);
   modport sink   (input valid, timed_out, remaining_ms, output ready);
endinterface

[sv/deadline_timer_sec_ms_top.sv]
// One-shot deadline timer with time kept as seconds and milliseconds.
// Depends on dts_pkg and on the channel interfaces in dts_if.sv.
//
// Usage: each request word carries an operation (set, restart, advance or
// query), a delay in milliseconds and the current time. Every request gives
// exactly one response word with the timeout flag and, for a query, the
// milliseconds left until the deadline.
// The block is a four-stage pipeline: input register, delay split (a multiply
// by the reciprocal of 1000), timer state update and response register, where
// the remaining time is formed. One word per cycle is sustained while the
// receiver takes responses.
// Each stage moves on when the stage after it is empty or moving, so requests
// keep being taken while a response waits; req ready falls only once all four
// stages hold a word and the receiver is stalling.
// Reset empties the pipeline, zeroes the deadline and the stored delay and
// leaves the timer reading as expired.
`timescale 1ns / 1ps
module deadline_timer_sec_ms_top import dts_pkg::*; (
   input logic        clock,
   input logic        reset,
   dts_req_if.sink    req_chan,
   dts_rsp_if.source  rsp_chan
);

   logic va_ff, va_in, vb_ff, vb_in, vc_ff, vc_in, vo_ff, vo_in;
   logic rdy_a, rdy_b, rdy_c;

   dts_stage_a_type a_ff, a_in;
   dts_stage_b_type b_ff, b_in;
   dts_stage_c_type c_ff, c_in;
   dts_out_type     o_ff, o_in;

   // The stored delay is kept already split into seconds and milliseconds.
   logic [WORD_W-1:0]   dl_sec_ff, dl_sec_in;
   logic [MSEC_W-1:0]   dl_msec_ff, dl_msec_in;
   logic [SD_SEC_W-1:0] sd_sec_ff, sd_sec_in;
   logic [MSEC_W-1:0]   sd_msec_ff, sd_msec_in;
   logic                expired_ff, expired_in;

   logic [SAT_W-1:0]    sat_dly;
   logic [PROD_W-1:0]   prod;
   logic [SD_SEC_W-1:0] quot;
   logic [MSEC_W-1:0]   rem;

   logic                zero_sel;
   logic [SD_SEC_W-1:0] add_sec;
   logic [MSEC_W-1:0]   add_msec;
   logic [WORD_W-1:0]   base_sec;
   logic [MSEC_W-1:0]   base_msec;
   logic [10:0]         msec_sum;
   logic [MSEC_W-1:0]   new_msec;
   logic [1:0]          carry;
   logic [WORD_W-1:0]   new_sec;
   logic [WORD_W-1:0]   diff_sec;
   logic signed [10:0]  diff_msec;
   logic                left_pos;
   logic [WORD_W-1:0]   left_ms;

   assign rdy_c = !vo_ff || rsp_chan.ready;
   assign rdy_b = !vc_ff || rdy_c;
   assign rdy_a = !vb_ff || rdy_b;
   assign req_chan.ready = !va_ff || rdy_a;

   assign rsp_chan.valid        = vo_ff;
   assign rsp_chan.timed_out    = o_ff.timed_out;
   assign rsp_chan.remaining_ms = o_ff.remaining_ms;

   always_comb begin
      va_in = req_chan.ready ? req_chan.valid : va_ff;
      vb_in = rdy_a ? va_ff : vb_ff;
      vc_in = rdy_b ? vb_ff : vc_ff;
      vo_in = rdy_c ? vc_ff : vo_ff;
   end

   always_comb begin
      a_in = a_ff;
      if (req_chan.ready) begin
         a_in.op       = dts_op_type'(req_chan.op);
         a_in.delay_ms = req_chan.delay_ms;
         a_in.now_sec  = req_chan.now_sec;
         a_in.now_msec = req_chan.now_msec;
      end
   end

   // Delay split: quotient by reciprocal multiply, remainder from its low bits.
   always_comb begin
      sat_dly = (a_ff.delay_ms > MAX_DELAY) ? MAX_DELAY[SAT_W-1:0]
                                            : a_ff.delay_ms[SAT_W-1:0];
      prod    = {{(PROD_W-SAT_W){1'b0}}, sat_dly} * {{(PROD_W-30){1'b0}}, RECIP_1000};
      quot    = prod[RECIP_SHIFT +: SD_SEC_W];
      rem     = sat_dly[MSEC_W-1:0] + {quot[4:0], 5'd0} - {quot[6:0], 3'd0};
      b_in    = b_ff;
      if (rdy_a) begin
         b_in.op       = a_ff.op;
         b_in.zero     = (a_ff.delay_ms == '0);
         b_in.dly_sec  = quot;
         b_in.dly_msec = rem;
         b_in.now_sec  = a_ff.now_sec;
         b_in.now_msec = a_ff.now_msec;
      end
   end

   always_comb begin
      zero_sel  = (b_ff.op == OP_SET) ? b_ff.zero : (sd_sec_ff == '0 && sd_msec_ff == '0);
      add_sec   = (b_ff.op == OP_SET) ? b_ff.dly_sec : sd_sec_ff;
      add_msec  = (b_ff.op == OP_SET) ? b_ff.dly_msec : sd_msec_ff;
      base_sec  = (b_ff.op == OP_ADVANCE) ? dl_sec_ff : b_ff.now_sec;
      base_msec = (b_ff.op == OP_ADVANCE) ? dl_msec_ff : b_ff.now_msec;
      msec_sum  = {1'b0, base_msec} + {1'b0, add_msec};
      if (msec_sum >= TWO_SEC_MS) begin
         new_msec = 10'(msec_sum - TWO_SEC_MS);
         carry    = 2'd2;
      end else if (msec_sum >= ONE_SEC_MS) begin
         new_msec = 10'(msec_sum - ONE_SEC_MS);
         carry    = 2'd1;
      end else begin
         new_msec = msec_sum[MSEC_W-1:0];
         carry    = 2'd0;
      end
      new_sec   = base_sec + {{(WORD_W-SD_SEC_W){1'b0}}, add_sec}
                  + {{(WORD_W-2){1'b0}}, carry};
      diff_sec  = dl_sec_ff - b_ff.now_sec;
      diff_msec = $signed({1'b0, dl_msec_ff}) - $signed({1'b0, b_ff.now_msec});
      left_pos  = !expired_ff && ((diff_sec != '0 && !diff_sec[WORD_W-1])
                  || (diff_sec == '0 && !diff_msec[10] && diff_msec != '0));
   end

   always_comb begin
      dl_sec_in  = dl_sec_ff;
      dl_msec_in = dl_msec_ff;
      sd_sec_in  = sd_sec_ff;
      sd_msec_in = sd_msec_ff;
      expired_in = expired_ff;
      if (vb_ff && rdy_b) begin
         case (b_ff.op)
            OP_SET, OP_RESTART: begin
               if (zero_sel) begin
                  sd_sec_in  = '0;
                  sd_msec_in = '0;
                  expired_in = 1'b1;
               end else begin
                  dl_sec_in  = new_sec;
                  dl_msec_in = new_msec;
                  sd_sec_in  = add_sec;
                  sd_msec_in = add_msec;
                  expired_in = 1'b0;
               end
            end
            OP_ADVANCE: begin
               dl_sec_in  = new_sec;
               dl_msec_in = new_msec;
               expired_in = 1'b0;
            end
            OP_QUERY: begin
               if (!left_pos) begin
                  expired_in = 1'b1;
               end
            end
            default: begin
               expired_in = expired_ff;
            end
         endcase
      end
      c_in = c_ff;
      if (rdy_b) begin
         c_in.timed_out = expired_in;
         c_in.live      = (b_ff.op == OP_QUERY) && left_pos;
         c_in.diff_sec  = diff_sec;
         c_in.diff_msec = diff_msec;
      end
   end

   // Remaining time: seconds times 1000 as 1024 - 32 + 8, plus the signed ms difference.
   always_comb begin
      left_ms = {c_ff.diff_sec[21:0], 10'd0} - {c_ff.diff_sec[26:0], 5'd0}
                + {c_ff.diff_sec[28:0], 3'd0}
                + {{(WORD_W-11){c_ff.diff_msec[10]}}, c_ff.diff_msec};
      o_in = o_ff;
      if (rdy_c) begin
         o_in.timed_out    = c_ff.timed_out;
         o_in.remaining_ms = c_ff.live ? left_ms : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff      <= 1'b0;
         vb_ff      <= 1'b0;
         vc_ff      <= 1'b0;
         vo_ff      <= 1'b0;
         dl_sec_ff  <= '0;
         dl_msec_ff <= '0;
         sd_sec_ff  <= '0;
         sd_msec_ff <= '0;
         expired_ff <= 1'b1;
      end else begin
         va_ff      <= va_in;
         vb_ff      <= vb_in;
         vc_ff      <= vc_in;
         vo_ff      <= vo_in;
         dl_sec_ff  <= dl_sec_in;
         dl_msec_ff <= dl_msec_in;
         sd_sec_ff  <= sd_sec_in;
         sd_msec_ff <= sd_msec_in;
         expired_ff <= expired_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff <= a_in;
      b_ff <= b_in;
      c_ff <= c_in;
      o_ff <= o_in;
   end

endmodule

[sv/dts_checker.sv]
// Port-level checks for the deadline timer, bound to its top level.
// Depends on assert_macros.svh; sees only the ports of deadline_timer_sec_ms_top.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module dts_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_timed_out,
   input logic [31:0] rsp_remaining_ms
);

   logic [2:0] cnt_ff, cnt_in;
   logic       in_fire, out_fire;

   assign in_fire  = req_valid && req_ready;
   assign out_fire = rsp_valid && rsp_ready;
   assign cnt_in   = cnt_ff + {2'b0, in_fire} - {2'b0, out_fire};

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_timed_out) && $stable(rsp_remaining_ms), "stalled response word changed")
   `ASSERT_SAME(a_timeout_zero, clock, reset, rsp_valid && rsp_timed_out, rsp_remaining_ms == 32'd0, "timed-out response reports time left")
   `ASSERT_SAME(a_no_phantom, clock, reset, cnt_ff == 3'd0, !rsp_valid, "response word without a pending request")
   `ASSERT_SAME(a_full_stall, clock, reset, !req_ready, rsp_valid && !rsp_ready && cnt_ff == 3'd4, "request refused while the pipeline can move")

endmodule

bind deadline_timer_sec_ms_top dts_checker u_dts_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_chan.valid),
   .req_ready        (req_chan.ready),
   .rsp_valid        (rsp_chan.valid),
   .rsp_ready        (rsp_chan.ready),
   .rsp_timed_out    (rsp_chan.timed_out),
   .rsp_remaining_ms (rsp_chan.remaining_ms)
);

[sim/dts_response_check.sv]
// Response checker for the seconds and milliseconds deadline timer: predicts each answer.
// Watches the request and response channels; depends on dts_pkg and the interfaces in dts_if.sv.
`timescale 1ns / 1ps
module dts_response_check import dts_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   dts_req_if          req_mon,
   dts_rsp_if          rsp_mon,
   output int unsigned errors,
   output int unsigned outstanding,
   output int unsigned answers_checked,
   output int unsigned timeouts_seen
);

   localparam int unsigned SHOWN_MAX = 40;

   logic [WORD_W-1:0] dl_sec;
   logic [MSEC_W-1:0] dl_msec;
   logic [SAT_W-1:0]  held_delay;
   logic              lapsed;
   dts_out_type       due_answers[$];

   task automatic note_mismatch(input string what, input logic [WORD_W-1:0] got,
                                input logic [WORD_W-1:0] want);
      if (errors < SHOWN_MAX) begin
         $display("%0t check: %s: got %0h, expected %0h", $time, what, got, want);
      end
      errors = errors + 1;
   endtask

   function automatic void push_deadline(input logic [SAT_W-1:0] step);
      logic [29:0] total;
      total = 30'(dl_msec) + 30'(step);
      dl_msec = MSEC_W'(total % ONE_SEC_MS);
      dl_sec = dl_sec + WORD_W'(total / ONE_SEC_MS);
   endfunction

   function automatic void arm_timer(input logic [WORD_W-1:0] ask,
                                     input logic [WORD_W-1:0] at_sec,
                                     input logic [MSEC_W-1:0] at_msec);
      logic [WORD_W-1:0] dly;
      dly = (ask > MAX_DELAY) ? MAX_DELAY : ask;
      if (dly != '0) begin
         dl_sec = at_sec;
         dl_msec = at_msec;
         held_delay = dly[SAT_W-1:0];
         lapsed = 1'b0;
         push_deadline(held_delay);
      end else begin
         held_delay = '0;
         lapsed = 1'b1;
      end
   endfunction

   function automatic logic [WORD_W-1:0] time_left(input logic [WORD_W-1:0] at_sec,
                                                   input logic [MSEC_W-1:0] at_msec);
      logic [WORD_W-1:0] d;
      int m;
      if (lapsed) return '0;
      d = dl_sec - at_sec;
      m = int'(dl_msec) - int'(at_msec);
      if (d != '0 && !d[WORD_W-1]) return d * WORD_W'(ONE_SEC_MS) + WORD_W'(m);
      if (d == '0 && m > 0) return WORD_W'(m);
      lapsed = 1'b1;
      return '0;
   endfunction

   function automatic dts_out_type timer_next(input dts_op_type op,
                                              input logic [WORD_W-1:0] delay,
                                              input logic [WORD_W-1:0] at_sec,
                                              input logic [MSEC_W-1:0] at_msec);
      dts_out_type ans;
      ans.remaining_ms = '0;
      case (op)
         OP_SET: arm_timer(delay, at_sec, at_msec);
         OP_RESTART: arm_timer(WORD_W'(held_delay), at_sec, at_msec);
         OP_ADVANCE: begin
            lapsed = 1'b0;
            push_deadline(held_delay);
         end
         default: ans.remaining_ms = time_left(at_sec, at_msec);
      endcase
      ans.timed_out = lapsed;
      return ans;
   endfunction

   always @(posedge clock) begin
      dts_out_type want;
      if (reset) begin
         dl_sec = '0;
         dl_msec = '0;
         held_delay = '0;
         lapsed = 1'b1;
         due_answers.delete();
         errors = 0;
         answers_checked = 0;
         timeouts_seen = 0;
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (due_answers.size() == 0) begin
               note_mismatch("response word with nothing expected", rsp_mon.remaining_ms, '0);
            end else begin
               want = due_answers.pop_front();
               answers_checked = answers_checked + 1;
               if (want.timed_out) timeouts_seen = timeouts_seen + 1;
               if (rsp_mon.timed_out !== want.timed_out) begin
                  note_mismatch("timed_out", WORD_W'(rsp_mon.timed_out),
                                WORD_W'(want.timed_out));
               end
               if (rsp_mon.remaining_ms !== want.remaining_ms) begin
                  note_mismatch("remaining_ms", rsp_mon.remaining_ms, want.remaining_ms);
               end
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            due_answers.push_back(timer_next(dts_op_type'(req_mon.op), req_mon.delay_ms,
                                             req_mon.now_sec, req_mon.now_msec));
         end
      end
      outstanding = due_answers.size();
   end

endmodule

[sim/tb.sv]
// Testbench top for the deadline timer: clock, reset, request stimulus and response stalls.
// Depends on dts_pkg, the interfaces in dts_if.sv, the timer top and dts_response_check.
`timescale 1ns / 1ps
module tb;
   import dts_pkg::*;

   localparam int unsigned RANDOM_ITEMS = 1900;
   localparam int unsigned STALL_LIMIT  = 2000;
   localparam int unsigned DRAIN_CYCLES = 8;

   logic clock;
   logic reset;

   dts_req_if req_bus ();
   dts_rsp_if rsp_bus ();

   int unsigned errors, outstanding, answers_checked, timeouts_seen;
   int unsigned op_tally[4];
   int unsigned rsp_stall;
   int unsigned idle_run;
   bit          quiet;
   logic [WORD_W-1:0] t_sec;
   logic [MSEC_W-1:0] t_msec;

   deadline_timer_sec_ms_top DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   dts_response_check u_check (
      .clock           (clock),
      .reset           (reset),
      .req_mon         (req_bus),
      .rsp_mon         (rsp_bus),
      .errors          (errors),
      .outstanding     (outstanding),
      .answers_checked (answers_checked),
      .timeouts_seen   (timeouts_seen)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int unsigned pick_gap();
      int unsigned r;
      if (quiet) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic logic [WORD_W-1:0] pick_delay();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return $urandom;
         2: return MAX_DELAY + $urandom_range(0, 4) - 2;
         default: return $urandom_range(1, 4000);
      endcase
   endfunction

   function automatic logic [MSEC_W-1:0] pick_msec();
      if ($urandom_range(0, 32) == 0) return MSEC_W'($urandom_range(1000, 1023));
      return t_msec;
   endfunction

   task automatic tick(input int unsigned ms);
      logic [31:0] total;
      total = 32'(t_msec) + ms;
      t_msec = MSEC_W'(total % ONE_SEC_MS);
      t_sec = t_sec + total / ONE_SEC_MS;
   endtask

   task automatic issue(input dts_op_type op, input logic [WORD_W-1:0] delay,
                        input logic [WORD_W-1:0] at_sec, input logic [MSEC_W-1:0] at_msec);
      int unsigned gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.op <= op;
      req_bus.delay_ms <= delay;
      req_bus.now_sec <= at_sec;
      req_bus.now_msec <= at_msec;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      op_tally[op] = op_tally[op] + 1;
   endtask

   always @(posedge clock) begin
      if (rsp_stall == 0) rsp_stall = pick_gap();
      if (rsp_stall > 0) begin
         rsp_bus.ready <= 1'b0;
         rsp_stall = rsp_stall - 1;
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         idle_run <= 0;
      end else begin
         idle_run <= idle_run + 1;
      end
      if (idle_run >= STALL_LIMIT) begin
         $display("tb: errors");
         $finish;
      end
   end

   initial begin
      int unsigned sent, run_len, r;
      dts_op_type op;
      reset <= 1'b1;
      req_bus.valid <= 1'b0;
      req_bus.op <= OP_SET;
      req_bus.delay_ms <= '0;
      req_bus.now_sec <= '0;
      req_bus.now_msec <= '0;
      quiet = 1'b0;
      rsp_stall = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      issue(OP_QUERY, '0, '0, '0);
      issue(OP_ADVANCE, '0, '0, '0);
      issue(OP_QUERY, '0, '0, '0);
      issue(OP_SET, '0, 32'd5, 10'd5);
      issue(OP_SET, 32'd1000, '0, '0);
      issue(OP_QUERY, '0, '0, 10'd999);
      issue(OP_QUERY, '0, 32'h8000_0002, '0);
      issue(OP_QUERY, '0, 32'd1, '0);
      issue(OP_RESTART, '0, 32'hFFFF_FFFF, 10'd999);
      issue(OP_QUERY, '0, '0, 10'd500);
      issue(OP_ADVANCE, 32'hFFFF_FFFF, '0, '0);
      issue(OP_QUERY, '0, 32'h8000_0001, '0);
      issue(OP_SET, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 10'd999);
      issue(OP_QUERY, '0, '0, '0);
      issue(OP_SET, MAX_DELAY + 1, 32'd100, 10'd1023);
      issue(OP_QUERY, '0, 32'd100, 10'd1023);
      issue(OP_SET, MAX_DELAY, 32'd7, '0);
      issue(OP_SET, 32'd1, 32'd10, 10'd1023);
      issue(OP_QUERY, '0, 32'd11, 10'd1023);
      issue(OP_SET, '0, '0, '0);
      issue(OP_RESTART, '0, 32'd3, 10'd3);
      issue(OP_ADVANCE, '0, '0, '0);
      issue(OP_QUERY, '0, '0, '0);
      issue(OP_SET, 32'd2500, 32'd1, 10'd900);
      issue(OP_QUERY, '0, 32'd3, 10'd100);

      t_sec = 32'hFFFF_FF00;
      t_msec = '0;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         if ($urandom_range(0, 9) == 0) quiet = !quiet;
         if ($urandom_range(0, 9) == 0) begin
            issue(dts_op_type'($urandom_range(0, 3)), $urandom, $urandom,
                  MSEC_W'($urandom_range(0, 1023)));
            sent = sent + 1;
         end else begin
            if ($urandom_range(0, 7) == 0) t_sec = $urandom;
            tick($urandom_range(0, 500));
            issue(OP_SET, pick_delay(), t_sec, pick_msec());
            sent = sent + 1;
            run_len = $urandom_range(1, 8);
            repeat (run_len) begin
               tick(($urandom_range(0, 19) == 0) ? $urandom_range(0, 9000000)
                                                 : $urandom_range(0, 1500));
               r = $urandom_range(0, 99);
               op = (r < 60) ? OP_QUERY : ((r < 80) ? OP_RESTART : OP_ADVANCE);
               issue(op, $urandom, t_sec, pick_msec());
               sent = sent + 1;
            end
         end
      end

      req_bus.valid <= 1'b0;
      @(posedge clock);
      wait (outstanding == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("summary: %0d request words: set %0d, restart %0d, advance %0d, query %0d",
               op_tally[0] + op_tally[1] + op_tally[2] + op_tally[3],
               op_tally[OP_SET], op_tally[OP_RESTART], op_tally[OP_ADVANCE],
               op_tally[OP_QUERY]);
      $display("summary: %0d response words checked, %0d of them timed out",
               answers_checked, timeouts_seen);
      if (errors == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end

endmodule

[filelist.f]
+incdir+sv
sv/dts_pkg.sv
sv/dts_if.sv
sv/deadline_timer_sec_ms_top.sv
sv/dts_checker.sv
sim/dts_response_check.sv
sim/tb.sv
